@@ src/hcfp_pkg.sv @@
// Shared types, codes and helpers for the hex command frame parser.
// No dependencies; every other file in src refers to this package by scoped name.
`timescale 1ns / 1ps

package hcfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned DIGIT_CNT_W = 4;
  localparam int unsigned KIND_W     = 2;

  // A value is complete once the sixteenth digit has arrived.
  localparam logic [DIGIT_CNT_W-1:0] DIGIT_LAST     = 4'd15;
  localparam logic [COUNT_W-1:0]     MAX_ARGS_RESET = 12'd64;

  localparam logic [KIND_W-1:0] KIND_HEADER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARGUMENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd2;

  localparam logic ERR_NOT_HEX  = 1'b0;
  localparam logic ERR_TOO_MANY = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               error_code;
    logic [BYTE_W-1:0]  command;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] arg_index;
    logic               last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_digit_t;

  // Lower-case hex digits only; anything else is flagged as not a digit.
  function automatic hex_digit_t decode_hex(input logic [BYTE_W-1:0] ch);
    hex_digit_t d;
    logic [BYTE_W-1:0] off;
    d   = '{ok: 1'b0, nibble: 4'd0};
    off = '0;
    if (ch inside {[8'h30:8'h39]}) begin
      off = ch - 8'h30;
      d   = '{ok: 1'b1, nibble: off[3:0]};
    end else if (ch inside {[8'h61:8'h66]}) begin
      off = ch - 8'h57;
      d   = '{ok: 1'b1, nibble: off[3:0]};
    end
    return d;
  endfunction

endpackage

@@ src/hcfp_parser.sv @@
// Frame parser state machine: command byte, count digits, argument digits, sticky error.
// Depends on hcfp_pkg for the result type, codes and the hex digit decoder.
`timescale 1ns / 1ps

module hcfp_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [hcfp_pkg::BYTE_W-1:0]  in_byte,
  input  logic [hcfp_pkg::COUNT_W-1:0] max_args,
  output logic                         res_valid,
  output hcfp_pkg::result_t            res
);

  typedef enum logic [1:0] {PH_CMD, PH_COUNT, PH_ARG, PH_ERR} phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [hcfp_pkg::BYTE_W-1:0]       command_r, command_nxt;
  logic [hcfp_pkg::VALUE_W-1:0]      acc_r, acc_nxt;
  logic [hcfp_pkg::DIGIT_CNT_W-1:0]  digit_cnt_r, digit_cnt_nxt;
  logic [hcfp_pkg::COUNT_W-1:0]      arg_total_r, arg_total_nxt;
  logic [hcfp_pkg::COUNT_W-1:0]      arg_done_r, arg_done_nxt;

  hcfp_pkg::hex_digit_t              digit;
  logic [hcfp_pkg::VALUE_W-1:0]      acc_shift;
  logic [hcfp_pkg::COUNT_W-1:0]      done_inc;
  logic                              full;
  logic                              too_many;

  always_comb begin
    digit     = hcfp_pkg::decode_hex(in_byte);
    acc_shift = {acc_r[hcfp_pkg::VALUE_W-5:0], digit.nibble};
    full      = (digit_cnt_r == hcfp_pkg::DIGIT_LAST);
    done_inc  = arg_done_r + 1'b1;
    // The whole 64-bit count is compared, not just its low twelve bits.
    too_many  = (|acc_shift[hcfp_pkg::VALUE_W-1:hcfp_pkg::COUNT_W]) ||
                (acc_shift[hcfp_pkg::COUNT_W-1:0] > max_args);

    phase_nxt     = phase_r;
    command_nxt   = command_r;
    acc_nxt       = acc_r;
    digit_cnt_nxt = digit_cnt_r;
    arg_total_nxt = arg_total_r;
    arg_done_nxt  = arg_done_r;

    res_valid      = 1'b0;
    res.kind       = hcfp_pkg::KIND_HEADER;
    res.error_code = hcfp_pkg::ERR_NOT_HEX;
    res.command    = command_r;
    res.value      = '0;
    res.arg_index  = '0;
    res.last       = 1'b0;

    case (phase_r)
      PH_CMD: begin
        command_nxt   = in_byte;
        acc_nxt       = '0;
        digit_cnt_nxt = '0;
        arg_total_nxt = '0;
        arg_done_nxt  = '0;
        phase_nxt     = PH_COUNT;
      end
      PH_COUNT, PH_ARG: begin
        if (!digit.ok) begin
          phase_nxt      = PH_ERR;
          res_valid      = 1'b1;
          res.kind       = hcfp_pkg::KIND_ERROR;
          res.error_code = hcfp_pkg::ERR_NOT_HEX;
          res.arg_index  = arg_done_r;
          res.last       = 1'b1;
        end else begin
          acc_nxt       = acc_shift;
          digit_cnt_nxt = digit_cnt_r + 1'b1;
          if (full) begin
            acc_nxt   = '0;
            res_valid = 1'b1;
            if (phase_r == PH_COUNT) begin
              if (too_many) begin
                phase_nxt      = PH_ERR;
                res.kind       = hcfp_pkg::KIND_ERROR;
                res.error_code = hcfp_pkg::ERR_TOO_MANY;
                res.last       = 1'b1;
              end else begin
                arg_total_nxt = acc_shift[hcfp_pkg::COUNT_W-1:0];
                arg_done_nxt  = '0;
                res.value     = acc_shift;
                if (acc_shift == '0) begin
                  phase_nxt = PH_CMD;
                  res.last  = 1'b1;
                end else begin
                  phase_nxt = PH_ARG;
                end
              end
            end else begin
              arg_done_nxt  = done_inc;
              res.kind      = hcfp_pkg::KIND_ARGUMENT;
              res.value     = acc_shift;
              res.arg_index = arg_done_r;
              res.last      = (done_inc == arg_total_r);
              if (done_inc == arg_total_r) begin
                phase_nxt = PH_CMD;
              end
            end
          end
        end
      end
      default: begin
        // Locked after an error: bytes are swallowed without a result.
      end
    endcase

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  // Only the phase needs a reset: the command phase clears everything else.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
    end else if (step) begin
      phase_r     <= phase_nxt;
      command_r   <= command_nxt;
      acc_r       <= acc_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      arg_total_r <= arg_total_nxt;
      arg_done_r  <= arg_done_nxt;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR |=> phase_r == PH_ERR)
    else $error("parser left the error phase without a reset");

  a_locked_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR |-> !res_valid)
    else $error("result produced while locked");

  a_error_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == hcfp_pkg::KIND_ERROR |-> res.last && phase_nxt == PH_ERR)
    else $error("error result without last or without locking");

  a_frame_end_to_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.last && res.kind != hcfp_pkg::KIND_ERROR |=> phase_r == PH_CMD)
    else $error("frame ended but parser does not await a command byte");

endmodule

@@ src/hcfp_out_reg.sv @@
// Result register between the parser and the output channel.
// Depends on hcfp_pkg for the result type.
`timescale 1ns / 1ps

module hcfp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  hcfp_pkg::result_t res,
  input  logic              out_tready,
  output logic              load_ok,
  output logic              out_valid,
  output hcfp_pkg::result_t res_out
);

  logic              valid_r, valid_nxt;
  hcfp_pkg::result_t res_r;

  // The register may be reloaded when it is empty or its beat leaves now.
  assign load_ok   = !valid_r || out_tready;
  assign valid_nxt = load_ok ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

@@ src/hex_command_frame_parser.sv @@
// Top level of the hex command frame parser: stream ports, max_args register.
// Depends on hcfp_pkg, hcfp_parser and hcfp_out_reg.
// A result is registered and appears on out_tvalid in the cycle after the byte that causes it.
// Throughput: one byte per cycle, set by the single output register; a stalled
// result holds in_tready low until it is taken.
// Reset (synchronous, rst_n low): parser awaits a command byte, no result pending,
// max_args returns to 64.
`timescale 1ns / 1ps

module hex_command_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [7:0] in_byte
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: [7:0] command, [71:8] value, [83:72] arg_index, [87:84] zero
  output logic [87:0]                   out_tdata,
  // out_tuser: [1:0] kind, [2] error_code
  output logic [2:0]                    out_tuser,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [hcfp_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready
);

  logic [hcfp_pkg::COUNT_W-1:0] max_args_r;
  logic                         step;
  logic                         load_ok;
  logic                         res_valid;
  hcfp_pkg::result_t            res;
  hcfp_pkg::result_t            res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r <= hcfp_pkg::MAX_ARGS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_args_r <= cfg_data;
    end
  end

  assign in_tready = load_ok;
  assign step      = in_tvalid && in_tready;

  hcfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_byte   (in_tdata),
    .max_args  (max_args_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hcfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_tready (out_tready),
    .load_ok    (load_ok),
    .out_valid  (out_tvalid),
    .res_out    (res_out)
  );

  assign out_tdata = {4'd0, res_out.arg_index, res_out.value, res_out.command};
  assign out_tuser = {res_out.error_code, res_out.kind};
  assign out_tlast = res_out.last;

endmodule
